// File: hdl/threshold_connected_pair_counter_macros.svh
// Assertion macros used by the threshold connected-pair counter datapath.
// Needs nothing else; included inside module bodies.
`ifndef THRESHOLD_CONNECTED_PAIR_COUNTER_MACROS_SVH
`define THRESHOLD_CONNECTED_PAIR_COUNTER_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define TCPC_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tcpc check failed");

// The consequent holds in the cycle after the antecedent.
`define TCPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpc check failed");

`endif

// File: hdl/tcpc_pkg.sv
// Types, codes and defaults of the threshold connected-pair counter.
// Depends on nothing; used by the controller, the datapath and the top level.
package tcpc_pkg;

   localparam int DEF_MAX_NODES   = 256;
   localparam int DEF_MAX_EDGES   = 256;
   localparam int DEF_MAX_QUERIES = 64;

   localparam logic [1:0] MODE_EDGE  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;

   localparam logic [14:0] PAIR_MAX = 15'h7fff;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  node_a;
      logic [7:0]  node_b;
      logic [15:0] edge_weight;
      logic [15:0] threshold;
   } req_type;

   typedef struct packed {
      logic [14:0] pair_count;
      logic [5:0]  query_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load_edge;
      logic load_query;
      logic run_start;
      logic run_clear;
      logic q_latch;
      logic clr_step;
      logic e_latch;
      logic next_e;
      logic p_latch;
      logic sz_rd_b;
      logic mul;
      logic merge;
      logic emit;
      logic next_q;
   } cmd_type;

   typedef struct packed {
      logic query_empty;
      logic last_query;
      logic clr_done;
      logic edges_done;
      logic over_limit;
      logic at_root;
      logic phase_b;
      logic same_root;
      logic out_free;
   } sts_type;

endpackage

// File: hdl/tcpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tcpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/tcpc_ctrl.sv
// Controller of the threshold connected-pair counter: sequences loads and runs.
// Depends on tcpc_pkg for the command and status structs.
module tcpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  tcpc_pkg::sts_type sts,
   output tcpc_pkg::cmd_type cmd
);
   import tcpc_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_QRD  = 4'd1;
   localparam logic [3:0] ST_QLAT = 4'd2;
   localparam logic [3:0] ST_CLR  = 4'd3;
   localparam logic [3:0] ST_ERD  = 4'd4;
   localparam logic [3:0] ST_ELAT = 4'd5;
   localparam logic [3:0] ST_FRD  = 4'd6;
   localparam logic [3:0] ST_FLAT = 4'd7;
   localparam logic [3:0] ST_CMP  = 4'd8;
   localparam logic [3:0] ST_SZA  = 4'd9;
   localparam logic [3:0] ST_SZB  = 4'd10;
   localparam logic [3:0] ST_MUL  = 4'd11;
   localparam logic [3:0] ST_MRG  = 4'd12;
   localparam logic [3:0] ST_EMIT = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_EDGE: begin
                     cmd.load_edge = 1'b1;
                  end
                  MODE_QUERY: begin
                     cmd.load_query = 1'b1;
                  end
                  MODE_RUN: begin
                     cmd.run_start = 1'b1;
                     if (sts.query_empty) begin
                        cmd.run_clear = 1'b1;
                     end else begin
                        state_in = ST_QRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QRD: begin
            state_in = ST_QLAT;
         end
         ST_QLAT: begin
            cmd.q_latch = 1'b1;
            state_in    = ST_CLR;
         end
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_ERD;
            end
         end
         ST_ERD: begin
            state_in = sts.edges_done ? ST_EMIT : ST_ELAT;
         end
         ST_ELAT: begin
            if (sts.over_limit) begin
               cmd.next_e = 1'b1;
               state_in   = ST_ERD;
            end else begin
               cmd.e_latch = 1'b1;
               state_in    = ST_FRD;
            end
         end
         ST_FRD: begin
            state_in = ST_FLAT;
         end
         ST_FLAT: begin
            cmd.p_latch = 1'b1;
            state_in    = (sts.at_root && sts.phase_b) ? ST_CMP : ST_FRD;
         end
         ST_CMP: begin
            if (sts.same_root) begin
               cmd.next_e = 1'b1;
               state_in   = ST_ERD;
            end else begin
               state_in = ST_SZA;
            end
         end
         ST_SZA: begin
            state_in = ST_SZB;
         end
         ST_SZB: begin
            cmd.sz_rd_b = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MRG;
         end
         ST_MRG: begin
            cmd.merge  = 1'b1;
            cmd.next_e = 1'b1;
            state_in   = ST_ERD;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.next_q = 1'b1;
               if (sts.last_query) begin
                  cmd.run_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_QRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: hdl/tcpc_dp.sv
// Datapath of the threshold connected-pair counter: stores, union-find and count.
// Depends on tcpc_pkg, tcpc_ram and the assertion macro header.
module tcpc_dp #(
   parameter int MAX_NODES   = tcpc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES   = tcpc_pkg::DEF_MAX_EDGES,
   parameter int MAX_QUERIES = tcpc_pkg::DEF_MAX_QUERIES
) (
   input  logic              clock,
   input  logic              reset,
   input  tcpc_pkg::req_type req_data,
   input  tcpc_pkg::cmd_type cmd,
   output tcpc_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcpc_pkg::rsp_type rsp_data
);
   import tcpc_pkg::*;
   `include "threshold_connected_pair_counter_macros.svh"

   localparam int NW  = $clog2(MAX_NODES);
   localparam int SW  = $clog2(MAX_NODES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int QAW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
   localparam int QCW = $clog2(MAX_QUERIES + 1);

   logic [ECW-1:0]  edge_count_ff;
   logic [QCW-1:0]  query_count_ff;
   logic [ECW-1:0]  e_ff;
   logic [QCW-1:0]  q_ff;
   logic [NW-1:0]   clr_ff;
   logic [15:0]     limit_ff;
   logic [NW-1:0]   x_ff;
   logic [NW-1:0]   b_ff;
   logic [NW-1:0]   ra_ff;
   logic [NW-1:0]   rb_ff;
   logic            phase_b_ff;
   logic [SW-1:0]   sa_ff;
   logic [SW-1:0]   sb_ff;
   logic [2*SW-1:0] prod_ff;
   logic [14:0]     total_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [31:0]     edge_rdata;
   logic [15:0]     query_rdata;
   logic [NW-1:0]   par_rdata;
   logic [SW-1:0]   size_rdata;
   logic            edge_ok;
   logic            query_ok;
   logic            par_we;
   logic [NW-1:0]   par_waddr;
   logic [NW-1:0]   par_wdata;
   logic [SW-1:0]   size_wdata;
   logic [NW-1:0]   size_raddr;
   logic [31:0]     sum;
   logic            last_q;

   assign edge_ok = (32'(req_data.node_a) < MAX_NODES) && (32'(req_data.node_b) < MAX_NODES)
                    && (edge_count_ff < ECW'(MAX_EDGES));
   assign query_ok = query_count_ff < QCW'(MAX_QUERIES);

   tcpc_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (cmd.load_edge && edge_ok),
      .wr_addr (edge_count_ff[EAW-1:0]),
      .wr_data ({req_data.edge_weight, req_data.node_b, req_data.node_a}),
      .rd_addr (e_ff[EAW-1:0]),
      .rd_data (edge_rdata)
   );

   tcpc_ram #(.WIDTH(16), .DEPTH(MAX_QUERIES)) u_query_ram (
      .clock   (clock),
      .wr_en   (cmd.load_query && query_ok),
      .wr_addr (query_count_ff[QAW-1:0]),
      .wr_data (req_data.threshold),
      .rd_addr (q_ff[QAW-1:0]),
      .rd_data (query_rdata)
   );

   assign par_we     = cmd.clr_step || cmd.merge;
   assign par_waddr  = cmd.clr_step ? clr_ff : ra_ff;
   assign par_wdata  = cmd.clr_step ? clr_ff : rb_ff;
   assign size_wdata = cmd.clr_step ? SW'(1) : SW'(sa_ff + sb_ff);
   assign size_raddr = cmd.sz_rd_b ? rb_ff : ra_ff;

   tcpc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (x_ff),
      .rd_data (par_rdata)
   );

   tcpc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_size_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (cmd.clr_step ? clr_ff : rb_ff),
      .wr_data (size_wdata),
      .rd_addr (size_raddr),
      .rd_data (size_rdata)
   );

   assign sum    = 32'(total_ff) + 32'(prod_ff);
   assign last_q = (QCW'(q_ff + QCW'(1)) == query_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff  <= '0;
         query_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.run_clear) begin
            edge_count_ff  <= '0;
            query_count_ff <= '0;
         end else begin
            if (cmd.load_edge && edge_ok) begin
               edge_count_ff <= ECW'(edge_count_ff + ECW'(1));
            end
            if (cmd.load_query && query_ok) begin
               query_count_ff <= QCW'(query_count_ff + QCW'(1));
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         q_ff <= '0;
      end else if (cmd.next_q) begin
         q_ff <= QCW'(q_ff + QCW'(1));
      end
      if (cmd.q_latch) begin
         limit_ff <= query_rdata;
         clr_ff   <= '0;
         e_ff     <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= NW'(clr_ff + NW'(1));
         end
         if (cmd.next_e) begin
            e_ff <= ECW'(e_ff + ECW'(1));
         end
      end
      if (cmd.e_latch) begin
         x_ff       <= NW'(edge_rdata[7:0]);
         b_ff       <= NW'(edge_rdata[15:8]);
         phase_b_ff <= 1'b0;
      end else if (cmd.p_latch) begin
         if (par_rdata != x_ff) begin
            x_ff <= par_rdata;
         end else if (!phase_b_ff) begin
            ra_ff      <= x_ff;
            x_ff       <= b_ff;
            phase_b_ff <= 1'b1;
         end else begin
            rb_ff <= x_ff;
         end
      end
      if (cmd.sz_rd_b) begin
         sa_ff <= size_rdata;
      end
      if (cmd.mul) begin
         sb_ff   <= size_rdata;
         prod_ff <= sa_ff * size_rdata;
      end
      if (cmd.merge) begin
         total_ff <= (sum > 32'(PAIR_MAX)) ? PAIR_MAX : sum[14:0];
      end
      if (cmd.emit) begin
         rsp_ff.pair_count  <= total_ff;
         rsp_ff.query_index <= 6'(q_ff);
         rsp_ff.last        <= last_q;
      end
   end

   always_comb begin
      sts.query_empty = (query_count_ff == '0);
      sts.last_query  = last_q;
      sts.clr_done    = (clr_ff == NW'(MAX_NODES - 1));
      sts.edges_done  = (e_ff == edge_count_ff);
      sts.over_limit  = (edge_rdata[31:16] > limit_ff);
      sts.at_root     = (par_rdata == x_ff);
      sts.phase_b     = phase_b_ff;
      sts.same_root   = (ra_ff == rb_ff);
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCPC_ASSERT_HOLDS(a_edge_cap, clock, reset, edge_count_ff <= ECW'(MAX_EDGES))
   `TCPC_ASSERT_HOLDS(a_query_cap, clock, reset, query_count_ff <= QCW'(MAX_QUERIES))
   `TCPC_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff)
   `TCPC_ASSERT_HOLDS(a_merge_roots, clock, reset, !cmd.merge || (ra_ff != rb_ff))
endmodule

// File: hdl/threshold_connected_pair_counter.sv
// Top level of the threshold connected-pair counter: controller plus datapath.
// Depends on tcpc_pkg, tcpc_ctrl, tcpc_dp and tcpc_ram.
//
//   Channel   Ports                          Moves
//   request   req_valid req_stall req_data   load edge, load query, run
//   result    rsp_valid rsp_stall rsp_data   one answer per stored query
//
// A run reads each stored query and clears the union-find, then reads each stored
// edge; an edge within the threshold walks both of its nodes up to their roots and,
// when the roots differ, reads both set sizes, adds their product to the pair count
// and merges the two sets. Each query ends with a step that sees the edges done and
// an emit step. Reset is synchronous and empties both stores. req_stall is high for
// the whole run; a stalled answer holds the run at its emit step.
module threshold_connected_pair_counter #(
   parameter int MAX_NODES   = tcpc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES   = tcpc_pkg::DEF_MAX_EDGES,
   parameter int MAX_QUERIES = tcpc_pkg::DEF_MAX_QUERIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcpc_pkg::rsp_type rsp_data
);
   import tcpc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tcpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcpc_dp #(
      .MAX_NODES   (MAX_NODES),
      .MAX_EDGES   (MAX_EDGES),
      .MAX_QUERIES (MAX_QUERIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
